>>> rtl/rqvr_pkg.sv
// shared types, constants and arithmetic helpers for the rate quaternion rotation block
package rqvr_pkg;

    localparam int DATA_W   = 32;
    localparam int PERIOD_W = 24;
    localparam int HALF_TURN_K_W = 29;
    localparam int PK_W = PERIOD_W + HALF_TURN_K_W;

    localparam logic [PERIOD_W-1:0]      PERIOD_RESET = 24'd167772;
    localparam logic [HALF_TURN_K_W-1:0] HALF_TURN_K  = 29'd341782638;
    localparam logic [PK_W-1:0] PK_RESET = PK_W'(64'd167772 * 64'd341782638);

    // cordic start value, reciprocal of the limit gain in q1.30
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
        logic signed [DATA_W-1:0] rate_x;
        logic signed [DATA_W-1:0] rate_y;
        logic signed [DATA_W-1:0] rate_z;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     saturated;
    } out_word_t;

    // arctangent of 2^-i in q0.32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // product >> 30, rounded half away from zero
    function automatic logic signed [41:0] rnd_q30(input logic signed [71:0] p);
        logic [71:0]        mag;
        logic [71:0]        r;
        logic signed [41:0] rr;
        mag = p[71] ? 72'(-p) : 72'(p);
        r   = (mag + 72'd536870912) >> 30;
        rr  = signed'(42'(r));
        return p[71] ? -rr : rr;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_dw(input logic signed [39:0] v,
                                                       output logic clip);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd2147483647;
        lo = -40'sd2147483648;
        clip = 1'b0;
        if (v > hi)
        begin
            clip = 1'b1;
            return hi[DATA_W-1:0];
        end
        else if (v < lo)
        begin
            clip = 1'b1;
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

>>> rtl/rate_quaternion_vector_rotation.sv
// top level: rate-driven quaternion rotation of a 3d vector, fully pipelined
//
// in channel: in_valid/in_ready with in_word (vector and angular rate, q16.16)
// out channel: out_valid/out_ready with out_word (rotated vector, q16.16, and a
//   flag set when any component was clipped)
// cfg_we/cfg_wdata load the sample period (q0.24 s); period times the half-turn
//   scale is registered at the write, so the user must write only while the
//   block is idle (the block does not enforce it); one word is taken per cycle
//   unless the pipe is held, and a word goes from accept to out_valid through the
//   input, phase multiply, phase sum, folded-phase and per-iteration cordic
//   registers, the euler and hamilton multiply/round stages and the output fifo;
//   every stage moves on one shared enable, and the two-word fifo lets the pipe keep taking words while a result waits
// when the receiver stalls with the fifo full and a result at the pipe's end,
//   the whole pipe holds and in_ready drops; nothing is lost or repeated
// reset clears all valid bits and the fifo, and loads the period reset value
module rate_quaternion_vector_rotation #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rqvr_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rqvr_pkg::out_word_t  out_word,
    input  logic                 cfg_we,
    input  logic [23:0]          cfg_wdata
);
    import rqvr_pkg::*;

    localparam int NCS = CORDIC_STEPS;

    logic en;
    logic push;
    logic pop;

    logic [PK_W-1:0] pk_reg;

    // s0: input
    logic                     vld_s0_reg;
    logic signed [DATA_W-1:0] v_s0_reg   [3];
    logic [DATA_W-1:0]        mag_s0_reg [3];
    logic                     neg_s0_reg [3];

    // s1: phase partial products
    logic                     vld_s1_reg;
    logic signed [DATA_W-1:0] v_s1_reg   [3];
    logic [58:0]              plo_s1_reg [3];
    logic [57:0]              phi_s1_reg [3];
    logic                     neg_s1_reg [3];

    // s2: phase in turns
    logic                     vld_s2_reg;
    logic signed [DATA_W-1:0] v_s2_reg   [3];
    logic [31:0]              ph_s2_reg  [3];
    logic                     neg_s2_reg [3];

    // cordic stages, entry 0 is the folded phase
    logic                     cvld_reg [NCS+1];
    logic signed [33:0]       cx_reg   [NCS+1][3];
    logic signed [33:0]       cy_reg   [NCS+1][3];
    logic signed [33:0]       cz_reg   [NCS+1][3];
    logic                     cfl_reg  [NCS+1][3];
    logic                     cng_reg  [NCS+1][3];
    logic signed [DATA_W-1:0] cv_reg   [NCS+1][3];

    // s4: cos and sin
    logic                     vld_s4_reg;
    logic signed [33:0]       cs_s4_reg [3];
    logic signed [33:0]       sn_s4_reg [3];
    logic signed [DATA_W-1:0] v_s4_reg  [3];

    // s5: first euler products
    logic                     vld_s5_reg;
    logic signed [67:0]       e1_s5_reg [4];
    logic signed [33:0]       cz_s5_reg;
    logic signed [33:0]       sz_s5_reg;
    logic signed [DATA_W-1:0] v_s5_reg  [3];

    // s6: rounded
    logic                     vld_s6_reg;
    logic signed [33:0]       a_s6_reg  [4];
    logic signed [33:0]       cz_s6_reg;
    logic signed [33:0]       sz_s6_reg;
    logic signed [DATA_W-1:0] v_s6_reg  [3];

    // s7: second euler products
    logic                     vld_s7_reg;
    logic signed [67:0]       e2_s7_reg [8];
    logic signed [DATA_W-1:0] v_s7_reg  [3];

    // s8: quaternion w, x, y, z
    logic                     vld_s8_reg;
    logic signed [33:0]       q_s8_reg  [4];
    logic signed [DATA_W-1:0] v_s8_reg  [3];

    // s9: q * (0,v) products
    logic                     vld_s9_reg;
    logic signed [65:0]       tp_s9_reg [12];
    logic signed [33:0]       q_s9_reg  [4];

    // s10: t
    logic                     vld_s10_reg;
    logic signed [35:0]       t_s10_reg [4];
    logic signed [33:0]       q_s10_reg [4];

    // s11: t * conj(q) products
    logic                     vld_s11_reg;
    logic signed [69:0]       rp_s11_reg [12];

    // s12: rotated vector
    logic                     vld_s12_reg;
    logic signed [39:0]       r_s12_reg [3];

    // output fifo
    out_word_t   fifo_reg [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    out_word_t   sat_word;

    logic signed [33:0] fold_z   [3];
    logic               fold_f   [3];
    logic signed [33:0] nx [NCS][3];
    logic signed [33:0] ny [NCS][3];
    logic signed [33:0] nz [NCS][3];

    assign en        = !vld_s12_reg || (cnt_reg != 2'd2) || out_ready;
    assign in_ready  = en;
    assign push      = en && vld_s12_reg;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_word  = fifo_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pk_reg <= PK_RESET;
        else if (cfg_we)
            pk_reg <= PK_W'(cfg_wdata) * PK_W'(HALF_TURN_K);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s0_reg  <= 1'b0;
            vld_s1_reg  <= 1'b0;
            vld_s2_reg  <= 1'b0;
            vld_s4_reg  <= 1'b0;
            vld_s5_reg  <= 1'b0;
            vld_s6_reg  <= 1'b0;
            vld_s7_reg  <= 1'b0;
            vld_s8_reg  <= 1'b0;
            vld_s9_reg  <= 1'b0;
            vld_s10_reg <= 1'b0;
            vld_s11_reg <= 1'b0;
            vld_s12_reg <= 1'b0;
            for (int k = 0; k <= NCS; k++)
                cvld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_s0_reg  <= in_valid;
            vld_s1_reg  <= vld_s0_reg;
            vld_s2_reg  <= vld_s1_reg;
            cvld_reg[0] <= vld_s2_reg;
            for (int k = 0; k < NCS; k++)
                cvld_reg[k+1] <= cvld_reg[k];
            vld_s4_reg  <= cvld_reg[NCS];
            vld_s5_reg  <= vld_s4_reg;
            vld_s6_reg  <= vld_s5_reg;
            vld_s7_reg  <= vld_s6_reg;
            vld_s8_reg  <= vld_s7_reg;
            vld_s9_reg  <= vld_s8_reg;
            vld_s10_reg <= vld_s9_reg;
            vld_s11_reg <= vld_s10_reg;
            vld_s12_reg <= vld_s11_reg;
        end
    end

    // front: magnitude, phase multiply, phase sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_s0_reg[0]   <= in_word.vec_x;
            v_s0_reg[1]   <= in_word.vec_y;
            v_s0_reg[2]   <= in_word.vec_z;
            neg_s0_reg[0] <= in_word.rate_x[DATA_W-1];
            neg_s0_reg[1] <= in_word.rate_y[DATA_W-1];
            neg_s0_reg[2] <= in_word.rate_z[DATA_W-1];
            mag_s0_reg[0] <= in_word.rate_x[DATA_W-1] ? DATA_W'(-in_word.rate_x)
                                                       : DATA_W'(in_word.rate_x);
            mag_s0_reg[1] <= in_word.rate_y[DATA_W-1] ? DATA_W'(-in_word.rate_y)
                                                       : DATA_W'(in_word.rate_y);
            mag_s0_reg[2] <= in_word.rate_z[DATA_W-1] ? DATA_W'(-in_word.rate_z)
                                                       : DATA_W'(in_word.rate_z);
            for (int a = 0; a < 3; a++)
            begin
                v_s1_reg[a]   <= v_s0_reg[a];
                neg_s1_reg[a] <= neg_s0_reg[a];
                plo_s1_reg[a] <= 59'(mag_s0_reg[a]) * 59'(pk_reg[26:0]);
                phi_s1_reg[a] <= 58'(mag_s0_reg[a]) * 58'(pk_reg[PK_W-1:27]);
                v_s2_reg[a]   <= v_s1_reg[a];
                neg_s2_reg[a] <= neg_s1_reg[a];
                ph_s2_reg[a]  <= 32'((85'(plo_s1_reg[a]) + (85'(phi_s1_reg[a]) << 27)) >> 40);
            end
        end
    end

    // fold the phase into [-1/4, 1/4] turn
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic signed [33:0] p;
            p = 34'(signed'(ph_s2_reg[a]));
            fold_z[a] = p;
            fold_f[a] = 1'b0;
            if (p > QUARTER_TURN)
            begin
                fold_z[a] = p - HALF_TURN;
                fold_f[a] = 1'b1;
            end
            else if (p < -QUARTER_TURN)
            begin
                fold_z[a] = p + HALF_TURN;
                fold_f[a] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cx_reg[0][a]  <= CORDIC_X0;
                cy_reg[0][a]  <= '0;
                cz_reg[0][a]  <= fold_z[a];
                cfl_reg[0][a] <= fold_f[a];
                cng_reg[0][a] <= neg_s2_reg[a];
                cv_reg[0][a]  <= v_s2_reg[a];
            end
        end
    end

    // one rotation-mode iteration per stage
    for (genvar k = 0; k < NCS; k++)
    begin : g_cordic
        always_comb
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic signed [33:0] at;
                at = signed'({2'b00, atan_turn(5'(k))});
                if (!cz_reg[k][a][33])
                begin
                    nx[k][a] = cx_reg[k][a] - (cy_reg[k][a] >>> k);
                    ny[k][a] = cy_reg[k][a] + (cx_reg[k][a] >>> k);
                    nz[k][a] = cz_reg[k][a] - at;
                end
                else
                begin
                    nx[k][a] = cx_reg[k][a] + (cy_reg[k][a] >>> k);
                    ny[k][a] = cy_reg[k][a] - (cx_reg[k][a] >>> k);
                    nz[k][a] = cz_reg[k][a] + at;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    cx_reg[k+1][a]  <= nx[k][a];
                    cy_reg[k+1][a]  <= ny[k][a];
                    cz_reg[k+1][a]  <= nz[k][a];
                    cfl_reg[k+1][a] <= cfl_reg[k][a];
                    cng_reg[k+1][a] <= cng_reg[k][a];
                    cv_reg[k+1][a]  <= cv_reg[k][a];
                end
            end
        end
    end

    // back end: euler terms, quaternion, two hamilton products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cs_s4_reg[a] <= cfl_reg[NCS][a] ? -cx_reg[NCS][a] : cx_reg[NCS][a];
                sn_s4_reg[a] <= (cfl_reg[NCS][a] ^ cng_reg[NCS][a]) ? -cy_reg[NCS][a]
                                                                      : cy_reg[NCS][a];
                v_s4_reg[a]  <= cv_reg[NCS][a];
                v_s5_reg[a]  <= v_s4_reg[a];
                v_s6_reg[a]  <= v_s5_reg[a];
                v_s7_reg[a]  <= v_s6_reg[a];
                v_s8_reg[a]  <= v_s7_reg[a];
            end

            // cx*cy, sx*sy, sx*cy, cx*sy
            e1_s5_reg[0] <= cs_s4_reg[0] * cs_s4_reg[1];
            e1_s5_reg[1] <= sn_s4_reg[0] * sn_s4_reg[1];
            e1_s5_reg[2] <= sn_s4_reg[0] * cs_s4_reg[1];
            e1_s5_reg[3] <= cs_s4_reg[0] * sn_s4_reg[1];
            cz_s5_reg    <= cs_s4_reg[2];
            sz_s5_reg    <= sn_s4_reg[2];

            for (int i = 0; i < 4; i++)
                a_s6_reg[i] <= 34'(rnd_q30(72'(e1_s5_reg[i])));
            cz_s6_reg <= cz_s5_reg;
            sz_s6_reg <= sz_s5_reg;

            e2_s7_reg[0] <= a_s6_reg[0] * cz_s6_reg;
            e2_s7_reg[1] <= a_s6_reg[1] * sz_s6_reg;
            e2_s7_reg[2] <= a_s6_reg[2] * cz_s6_reg;
            e2_s7_reg[3] <= a_s6_reg[3] * sz_s6_reg;
            e2_s7_reg[4] <= a_s6_reg[3] * cz_s6_reg;
            e2_s7_reg[5] <= a_s6_reg[2] * sz_s6_reg;
            e2_s7_reg[6] <= a_s6_reg[0] * sz_s6_reg;
            e2_s7_reg[7] <= a_s6_reg[1] * cz_s6_reg;

            q_s8_reg[0] <= 34'(rnd_q30(72'(e2_s7_reg[0])) + rnd_q30(72'(e2_s7_reg[1])));
            q_s8_reg[1] <= 34'(rnd_q30(72'(e2_s7_reg[2])) - rnd_q30(72'(e2_s7_reg[3])));
            q_s8_reg[2] <= 34'(rnd_q30(72'(e2_s7_reg[4])) + rnd_q30(72'(e2_s7_reg[5])));
            q_s8_reg[3] <= 34'(rnd_q30(72'(e2_s7_reg[6])) - rnd_q30(72'(e2_s7_reg[7])));

            // q index: 0 w, 1 x, 2 y, 3 z
            tp_s9_reg[0]  <= v_s8_reg[0] * q_s8_reg[1];
            tp_s9_reg[1]  <= v_s8_reg[1] * q_s8_reg[2];
            tp_s9_reg[2]  <= v_s8_reg[2] * q_s8_reg[3];
            tp_s9_reg[3]  <= v_s8_reg[0] * q_s8_reg[0];
            tp_s9_reg[4]  <= v_s8_reg[2] * q_s8_reg[2];
            tp_s9_reg[5]  <= v_s8_reg[1] * q_s8_reg[3];
            tp_s9_reg[6]  <= v_s8_reg[1] * q_s8_reg[0];
            tp_s9_reg[7]  <= v_s8_reg[2] * q_s8_reg[1];
            tp_s9_reg[8]  <= v_s8_reg[0] * q_s8_reg[3];
            tp_s9_reg[9]  <= v_s8_reg[2] * q_s8_reg[0];
            tp_s9_reg[10] <= v_s8_reg[1] * q_s8_reg[1];
            tp_s9_reg[11] <= v_s8_reg[0] * q_s8_reg[2];
            for (int i = 0; i < 4; i++)
            begin
                q_s9_reg[i]  <= q_s8_reg[i];
                q_s10_reg[i] <= q_s9_reg[i];
            end

            t_s10_reg[0] <= 36'(-rnd_q30(72'(tp_s9_reg[0])) - rnd_q30(72'(tp_s9_reg[1]))
                                - rnd_q30(72'(tp_s9_reg[2])));
            t_s10_reg[1] <= 36'(rnd_q30(72'(tp_s9_reg[3])) + rnd_q30(72'(tp_s9_reg[4]))
                                - rnd_q30(72'(tp_s9_reg[5])));
            t_s10_reg[2] <= 36'(rnd_q30(72'(tp_s9_reg[6])) - rnd_q30(72'(tp_s9_reg[7]))
                                + rnd_q30(72'(tp_s9_reg[8])));
            t_s10_reg[3] <= 36'(rnd_q30(72'(tp_s9_reg[9])) + rnd_q30(72'(tp_s9_reg[10]))
                                - rnd_q30(72'(tp_s9_reg[11])));

            rp_s11_reg[0]  <= t_s10_reg[0] * q_s10_reg[1];
            rp_s11_reg[1]  <= t_s10_reg[1] * q_s10_reg[0];
            rp_s11_reg[2]  <= t_s10_reg[2] * q_s10_reg[3];
            rp_s11_reg[3]  <= t_s10_reg[3] * q_s10_reg[2];
            rp_s11_reg[4]  <= t_s10_reg[0] * q_s10_reg[2];
            rp_s11_reg[5]  <= t_s10_reg[1] * q_s10_reg[3];
            rp_s11_reg[6]  <= t_s10_reg[2] * q_s10_reg[0];
            rp_s11_reg[7]  <= t_s10_reg[3] * q_s10_reg[1];
            rp_s11_reg[8]  <= t_s10_reg[0] * q_s10_reg[3];
            rp_s11_reg[9]  <= t_s10_reg[1] * q_s10_reg[2];
            rp_s11_reg[10] <= t_s10_reg[2] * q_s10_reg[1];
            rp_s11_reg[11] <= t_s10_reg[3] * q_s10_reg[0];

            r_s12_reg[0] <= 40'(-rnd_q30(72'(rp_s11_reg[0])) + rnd_q30(72'(rp_s11_reg[1]))
                                - rnd_q30(72'(rp_s11_reg[2])) + rnd_q30(72'(rp_s11_reg[3])));
            r_s12_reg[1] <= 40'(-rnd_q30(72'(rp_s11_reg[4])) + rnd_q30(72'(rp_s11_reg[5]))
                                + rnd_q30(72'(rp_s11_reg[6])) - rnd_q30(72'(rp_s11_reg[7])));
            r_s12_reg[2] <= 40'(-rnd_q30(72'(rp_s11_reg[8])) - rnd_q30(72'(rp_s11_reg[9]))
                                + rnd_q30(72'(rp_s11_reg[10])) + rnd_q30(72'(rp_s11_reg[11])));
        end
    end

    // clip to the output range on the way into the fifo
    always_comb
    begin
        logic c0;
        logic c1;
        logic c2;
        sat_word.out_x     = sat_dw(r_s12_reg[0], c0);
        sat_word.out_y     = sat_dw(r_s12_reg[1], c1);
        sat_word.out_z     = sat_dw(r_s12_reg[2], c2);
        sat_word.saturated = c0 | c1 | c2;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= sat_word;
    end

endmodule

>>> rtl/rqvr_chk.sv
// port-level checker for the rate quaternion rotation block, bound to the top level
module rqvr_chk #(
    parameter int CORDIC_STEPS = 20
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input rqvr_pkg::out_word_t  out_word
);
    // pipe stages plus the two fifo slots
    localparam int CAP   = CORDIC_STEPS + 15;
    localparam int CNT_W = $clog2(CAP + 1);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             acc_in;
    logic             acc_out;

    assign acc_in  = in_valid && in_ready;
    assign acc_out = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (acc_in && !acc_out)
            inflight_next = inflight_reg + CNT_W'(1);
        else if (acc_out && !acc_in)
            inflight_next = inflight_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // a held result keeps its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // input only backs up behind a stalled full output
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    // no result without an accepted word behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        acc_out |-> inflight_reg != '0)
        else $error("result delivered with no word in flight");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(CAP))
        else $error("more words in flight than the pipe holds");

    // no result reaches the output in the cycle after an accept into an empty pipe
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 && acc_in |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind rate_quaternion_vector_rotation rqvr_chk #(.CORDIC_STEPS(CORDIC_STEPS)) u_rqvr_chk (.*);

>>> sim/rqvr_checker.sv
// checker for the rate quaternion rotation block: predicts and compares result words
`timescale 1ns / 1ps

module rqvr_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  rqvr_pkg::in_word_t  in_word,
    input  logic                out_valid,
    input  logic                out_ready,
    input  rqvr_pkg::out_word_t out_word,
    input  logic                cfg_we,
    input  logic [23:0]         cfg_wdata,
    output int                  fail_count,
    output int                  pending
);
    import rqvr_pkg::*;

    localparam int STEPS = 20;
    localparam longint GAIN_X0 = 652032874;
    localparam longint TURN_K = 341782638;

    logic [23:0] period_q24;
    out_word_t   rotated_q[$];

    function automatic longint atan_q32(input int i);
        longint tbl[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
            10, 5, 3, 1, 1, 0};
        return tbl[i];
    endfunction

    // (a*b)>>30 rounded half away from zero
    function automatic longint mulr(input longint a, input longint b);
        logic signed [127:0] p;
        logic [127:0]        m;
        longint              r;
        p = 128'(signed'(a)) * 128'(signed'(b));
        m = p[127] ? -p : p;
        r = longint'((m + 128'd536870912) >> 30);
        return p[127] ? -r : r;
    endfunction

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    task automatic half_trig(input longint rate, output longint c, output longint s);
        logic [127:0] prod;
        logic [31:0]  ph;
        longint       p, x, y, z, nx;
        bit           flip;
        prod = 128'(rate < 0 ? -rate : rate) * 128'(longint'(period_q24) * TURN_K);
        ph = prod[71:40];
        p = longint'(ph);
        if (p >= 64'sd2147483648) p -= 64'sd4294967296;
        flip = 0;
        if (p > 64'sd1073741824)
        begin
            p -= 64'sd2147483648;
            flip = 1;
        end
        else if (p < -64'sd1073741824)
        begin
            p += 64'sd2147483648;
            flip = 1;
        end
        x = GAIN_X0;
        y = 0;
        z = p;
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= atan_q32(i);
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += atan_q32(i);
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        if (rate < 0) y = -y;
        c = x;
        s = y;
    endtask

    function automatic logic [31:0] clamp32(input longint v, inout logic clip);
        if (v > 64'sd2147483647)
        begin
            clip = 1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            clip = 1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    task automatic rotate_word(input in_word_t w, output out_word_t r);
        longint vx, vy, vz, cx, sx, cy, sy, cz, sz, qw, qx, qy, qz, tw, tx, ty, tz;
        longint rx, ry, rz;
        logic   clip;
        vx = w.vec_x;
        vy = w.vec_y;
        vz = w.vec_z;
        half_trig(longint'(w.rate_x), cx, sx);
        half_trig(longint'(w.rate_y), cy, sy);
        half_trig(longint'(w.rate_z), cz, sz);
        qw = mulr(mulr(cx, cy), cz) + mulr(mulr(sx, sy), sz);
        qx = mulr(mulr(sx, cy), cz) - mulr(mulr(cx, sy), sz);
        qy = mulr(mulr(cx, sy), cz) + mulr(mulr(sx, cy), sz);
        qz = mulr(mulr(cx, cy), sz) - mulr(mulr(sx, sy), cz);
        tw = -mulr(vx, qx) - mulr(vy, qy) - mulr(vz, qz);
        tx = mulr(vx, qw) + mulr(vz, qy) - mulr(vy, qz);
        ty = mulr(vy, qw) - mulr(vz, qx) + mulr(vx, qz);
        tz = mulr(vz, qw) + mulr(vy, qx) - mulr(vx, qy);
        rx = -mulr(tw, qx) + mulr(tx, qw) - mulr(ty, qz) + mulr(tz, qy);
        ry = -mulr(tw, qy) + mulr(tx, qz) + mulr(ty, qw) - mulr(tz, qx);
        rz = -mulr(tw, qz) - mulr(tx, qy) + mulr(ty, qx) + mulr(tz, qw);
        clip = 0;
        r.out_x = clamp32(rx, clip);
        r.out_y = clamp32(ry, clip);
        r.out_z = clamp32(rz, clip);
        r.saturated = clip;
    endtask

    assign pending = rotated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        if (!rst_n)
        begin
            period_q24 <= PERIOD_RESET;
            fail_count <= 0;
            rotated_q.delete();
        end
        else
        begin
            if (cfg_we) period_q24 <= cfg_wdata;
            if (in_valid && in_ready)
            begin
                rotate_word(in_word, exp_w);
                rotated_q.push_back(exp_w);
            end
            if (out_valid && out_ready)
            begin
                if (rotated_q.size() == 0)
                begin
                    $error("unexpected result word %h", out_word);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = rotated_q.pop_front();
                    if (out_word.out_x !== exp_w.out_x)
                        $error("out_x expected %h actual %h", exp_w.out_x, out_word.out_x);
                    if (out_word.out_y !== exp_w.out_y)
                        $error("out_y expected %h actual %h", exp_w.out_y, out_word.out_y);
                    if (out_word.out_z !== exp_w.out_z)
                        $error("out_z expected %h actual %h", exp_w.out_z, out_word.out_z);
                    if (out_word.saturated !== exp_w.saturated)
                        $error("saturated expected %b actual %b", exp_w.saturated,
                               out_word.saturated);
                    if (out_word !== exp_w) fail_count <= fail_count + 1;
                end
            end
        end
    end
endmodule

>>> sim/testbench.sv
// testbench top: stimulus, configuration phases and verdict for the rotation block
`timescale 1ns / 1ps

module testbench;
    import rqvr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_word;
    logic        cfg_we;
    logic [23:0] cfg_wdata;
    int          fail_count;
    int          pending;
    bit          stall_on;

    rate_quaternion_vector_rotation dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_word(in_word), .out_valid(out_valid), .out_ready(out_ready),
        .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    rqvr_checker chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_word(in_word), .out_valid(out_valid), .out_ready(out_ready),
        .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // receiver stalls, with quiet stretches that never stall
    always @(posedge clk)
    begin
        if (!stall_on) out_ready <= 1'b1;
        else out_ready <= (gap_len() == 0);
    end

    initial
    begin
        stall_on = 1;
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            stall_on = ~stall_on;
        end
    end

    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'(signed'($urandom_range(0, 131072)) - 65536);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return pick_field();
            1: return 32'(signed'($urandom_range(0, 1310720)) - 655360);
            default: return 32'(signed'($urandom_range(0, 65536 * 400)) - 65536 * 200);
        endcase
    endfunction

    // valid stays high into the next word when there is no gap
    task automatic send_word(input in_word_t w);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random(input int n);
        in_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.vec_x = pick_field();
            w.vec_y = pick_field();
            w.vec_z = pick_field();
            w.rate_x = pick_rate();
            w.rate_y = pick_rate();
            w.rate_z = pick_rate();
            send_word(w);
        end
    endtask

    task automatic write_period(input logic [23:0] p);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [23:0] periods[6];
        logic [31:0] edge_vals[4];
        int          waited;
        periods = '{24'd0, 24'hffffff, 24'd1, 24'd167772, 24'h800000, 24'd0};
        edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
        in_valid = 0;
        in_word = '0;
        cfg_we = 0;
        cfg_wdata = '0;
        out_ready = 0;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // directed: identity, extremes, saturation, exact half turn
        send_word('{32'h10000, 32'h20000, 32'h30000, 32'h0, 32'h0, 32'h0});
        foreach (edge_vals[i])
            send_word('{edge_vals[i], edge_vals[i], edge_vals[i],
                        edge_vals[i], edge_vals[3 - i], edge_vals[i]});
        send_word('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h10000, 32'h8000, 32'h20000});
        write_period(24'h800000);
        // rate pi rad/s at T=0.5 gives half-angle pi/4 rad, rate 2*pi for a half turn
        send_word('{32'h10000, 32'h0, 32'h0, 32'h3243f, 32'h0, 32'h0});
        send_word('{32'h0, 32'h10000, 32'h0, 32'h0, 32'hfffcdbc1, 32'h0});
        send_word('{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h6487e, 32'h6487e, 32'h6487e});
        write_period(24'hffffff);
        send_word('{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'h12345678});
        send_random(10);

        foreach (periods[i])
        begin
            write_period(periods[i]);
            send_random(110);
        end
        write_period($urandom_range(0, 24'hffffff));
        send_random(30);
        in_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("rate_quaternion_vector_rotation regression: pass");
        else
            $display("rate_quaternion_vector_rotation regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("rate_quaternion_vector_rotation regression: fail");
        $finish;
    end
endmodule
